// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define ARC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define ARC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/arc_pkg.sv
`timescale 1ns / 1ps

package arc_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_STATS   = 2'd1;
    localparam logic [1:0] OP_RENDER  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 2'd2;

    localparam int COUNT_W    = 5;   // palette_count register width
    localparam int IDX_W      = 5;   // internal palette index, holds count - 1
    localparam int ENTRY_W    = 4;   // entry_index field
    localparam int COLOR_W    = 32;  // RGBA entry
    localparam int CINDEX_W   = 4;   // color_index field
    localparam int IN_USER_W  = 4;   // operation, sample_invalid, first_of_pass
    localparam int OUT_DATA_W = 40;  // 4 x 8-bit color + 4-bit index, byte padded

    localparam logic [COUNT_W-1:0] PALETTE_COUNT_RST = 5'd2;

    typedef struct packed {
        logic accept;    // item taken this cycle
        logic calc;      // register span and offset
        logic mul;       // register product, pick direct index cases
        logic div_step;  // one restoring divide step
        logic rd;        // palette read
        logic load_out;  // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic render;    // item on the input is a render sample
        logic qual;      // item on the input is neither invalid nor nodata
        logic need_div;  // offset strictly inside the range
    } t_dp_status;

endpackage

// File: sv/arc_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output arc_pkg::t_dp_cmd      o_cmd,
    input  arc_pkg::t_dp_status   i_status
);
    import arc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int CNT_W = $clog2(IDX_W);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_load;

    assign w_accept = i_s_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_OUT) && (!r_out_valid || i_m_ready);

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = w_accept;
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.rd       = (r_state == S_READ);
        o_cmd.load_out = w_load;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_status.render) begin
                    n_state = i_status.qual ? S_CALC : S_OUT;
                end
            end
            S_CALC: n_state = S_MUL;
            S_MUL: begin
                if (i_status.need_div) begin
                    n_state = S_DIV;
                    n_cnt   = CNT_W'(IDX_W - 1);
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_READ;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_READ: n_state = S_OUT;
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

    `ARC_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_load && r_out_valid && !i_m_ready, "result overwritten before taken")
    `ARC_ASSERT(a_div_ends, i_clk, i_rst_n, (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_READ), "divide did not finish in time")
    `ARC_ASSERT(a_render_start, i_clk, i_rst_n, (w_accept && i_status.render && i_status.qual) |=> (r_state == S_CALC), "render item not started")

endmodule

// File: sv/arc_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arc_datapath #(
    parameter int MAX_PALETTE = 16,
    parameter int SAMPLE_BITS = 32,
    parameter int IN_DATA_W   = 72
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  arc_pkg::t_dp_cmd               i_cmd,
    output arc_pkg::t_dp_status            o_status,
    input  logic                           i_cfg_valid,
    input  logic [arc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]         i_cfg_data,
    input  logic [IN_DATA_W-1:0]           i_tdata,
    input  logic [arc_pkg::IN_USER_W-1:0]  i_tuser,
    output logic [arc_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                           o_tuser
);
    import arc_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int PW = $clog2(MAX_PALETTE);
    localparam int RW = S + IDX_W;   // product / remainder width

    // configuration
    logic [S-1:0]       r_nodata;
    logic               r_nodata_en;
    logic [COUNT_W-1:0] r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodata    <= '0;
            r_nodata_en <= 1'b0;
            r_pc        <= PALETTE_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODATA_VALUE:  r_nodata    <= i_cfg_data;
                CFG_NODATA_ENABLE: r_nodata_en <= i_cfg_data[0];
                CFG_PALETTE_COUNT: r_pc        <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input item fields
    logic [1:0]         w_op;
    logic               w_invalid;
    logic               w_first;
    logic [S-1:0]       w_sample;
    logic [ENTRY_W-1:0] w_entry_idx;
    logic [COLOR_W-1:0] w_entry_color;
    logic               w_qual;

    assign w_op          = i_tuser[1:0];
    assign w_invalid     = i_tuser[2];
    assign w_first       = i_tuser[3];
    assign w_sample      = i_tdata[S-1:0];
    assign w_entry_idx   = i_tdata[S +: ENTRY_W];
    assign w_entry_color = i_tdata[S+ENTRY_W +: COLOR_W];
    assign w_qual        = !w_invalid && !(r_nodata_en && (w_sample == r_nodata));

    // running range
    logic [S-1:0] r_min, n_min;
    logic [S-1:0] r_max, n_max;
    logic         r_seen, n_seen;
    logic         w_seen_eff;

    always_comb begin
        n_min      = r_min;
        n_max      = r_max;
        n_seen     = r_seen;
        w_seen_eff = r_seen && !w_first;
        if (i_cmd.accept && (w_op == OP_STATS)) begin
            n_seen = w_seen_eff;
            if (w_qual) begin
                n_seen = 1'b1;
                if (!w_seen_eff) begin
                    n_min = w_sample;
                    n_max = w_sample;
                end else begin
                    if ($signed(w_sample) < $signed(r_min)) begin
                        n_min = w_sample;
                    end
                    if ($signed(w_sample) > $signed(r_max)) begin
                        n_max = w_sample;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_max  <= '0;
            r_seen <= 1'b0;
        end else begin
            r_min  <= n_min;
            r_max  <= n_max;
            r_seen <= n_seen;
        end
    end

    // highest index in use: count clamped to 1..MAX_PALETTE, minus one
    logic [IDX_W-1:0] w_top;

    always_comb begin
        if (r_pc == '0) begin
            w_top = '0;
        end else if (32'(r_pc) > 32'(MAX_PALETTE)) begin
            w_top = IDX_W'(MAX_PALETTE - 1);
        end else begin
            w_top = r_pc - 1'b1;
        end
    end

    // render path
    logic [S-1:0]     r_v;
    logic             r_skip;
    logic [S:0]       r_span;
    logic [S:0]       r_d;
    logic [IDX_W-1:0] r_top;
    logic [IDX_W-1:0] r_idx;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    r_dvs;

    logic          w_span_pos;
    logic          w_d_pos;
    logic          w_d_ge;
    logic          w_need_div;
    logic [RW-1:0] w_prod;
    logic          w_ge;

    assign w_span_pos = !r_span[S] && (r_span != '0);
    assign w_d_pos    = !r_d[S] && (r_d != '0);
    assign w_d_ge     = ($signed(r_d) >= $signed(r_span));
    assign w_need_div = w_span_pos && w_d_pos && !w_d_ge;
    // 0 < d < span, so d fits S bits unsigned
    assign w_prod     = RW'(r_d[S-1:0]) * RW'(r_top);
    assign w_ge       = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (w_op == OP_RENDER)) begin
            r_v    <= w_sample;
            r_skip <= !w_qual;
        end
        if (i_cmd.calc) begin
            r_span <= {r_max[S-1], r_max} - {r_min[S-1], r_min};
            r_d    <= {r_v[S-1], r_v} - {r_min[S-1], r_min};
            r_top  <= w_top;
        end
        if (i_cmd.mul) begin
            r_rem <= w_prod;
            r_dvs <= {1'b0, r_span[S-1:0], {(IDX_W-1){1'b0}}};
            if (!w_span_pos) begin
                r_idx <= r_top >> 1;
            end else if (!w_d_pos) begin
                r_idx <= '0;
            end else if (w_d_ge) begin
                r_idx <= r_top;
            end else begin
                r_idx <= '0;
            end
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_idx <= {r_idx[IDX_W-2:0], w_ge};
        end
    end

    // palette memory
    logic [COLOR_W-1:0]    r_palette [MAX_PALETTE];
    logic [COLOR_W-1:0]    r_rd_data;
    logic [PW+ENTRY_W-1:0] w_wr_ext;
    logic [PW+IDX_W-1:0]   w_rd_ext;
    logic                  w_wr_ok;

    assign w_wr_ext = {{PW{1'b0}}, w_entry_idx};
    assign w_rd_ext = {{PW{1'b0}}, r_idx};
    assign w_wr_ok  = (32'(w_entry_idx) < 32'(MAX_PALETTE));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (w_op == OP_PALETTE) && w_wr_ok) begin
            r_palette[w_wr_ext[PW-1:0]] <= w_entry_color;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_palette[w_rd_ext[PW-1:0]];
        end
    end

    // output register
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_skip;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_skip) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {{(OUT_DATA_W - 4*8 - CINDEX_W){1'b0}},
                               r_idx[CINDEX_W-1:0],
                               r_rd_data[7:0],
                               r_rd_data[15:8],
                               r_rd_data[23:16],
                               r_rd_data[31:24]};
            end
            r_out_skip <= r_skip;
        end
    end

    assign o_tdata = r_out_data;
    assign o_tuser = r_out_skip;

    always_comb begin
        o_status          = '0;
        o_status.render   = (w_op == OP_RENDER);
        o_status.qual     = w_qual;
        o_status.need_div = w_need_div;
    end

    `ARC_ASSERT(a_min_le_max, i_clk, i_rst_n, $signed(r_min) <= $signed(r_max), "range min above max")
    `ARC_ASSERT(a_idx_in_range, i_clk, i_rst_n, i_cmd.rd |-> (r_idx <= r_top), "palette index beyond count")
    `ARC_ASSERT(a_calc_not_skipped, i_clk, i_rst_n, i_cmd.mul |-> !r_skip, "skipped sample sent to compute path")

endmodule

// File: sv/auto_range_colormap.sv
`timescale 1ns / 1ps

// Min/max auto-ranged palette colormap. Samples are signed Q16.16 with an
// invalid flag; tuser selects palette write, statistics sample or render
// sample. Statistics samples update a running min/max of samples that are
// neither invalid nor nodata (first_of_pass restarts it); render samples
// return floor((v-min)*(n-1)/(max-min)) clamped to 0..n-1, or (n-1)>>1 on a
// flat range, with that palette entry's RGBA; invalid or nodata samples
// return all zeros with skipped set. Palette writes and statistics samples
// give no result and leave the block idle for the next item. A render sample
// passes calc, mul, read and output states, with the 5-step restoring divider
// (one index bit per cycle) between mul and read when the offset lies strictly
// inside the range; a skipped one goes straight to output. Results sit in an
// output register, so following palette and statistics items are taken while
// a result waits. Unwritten palette entries return undefined color. The user
// writes configuration only when idle; the block does not enforce this.
module auto_range_colormap #(
    parameter int MAX_PALETTE = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample, entry_index, entry_color (low to high), zero padded
    input  logic [((SAMPLE_BITS + arc_pkg::ENTRY_W + arc_pkg::COLOR_W + 7) / 8) * 8 - 1:0]
                                           s_axis_tdata,
    // operation[1:0], sample_invalid[2], first_of_pass[3]
    input  logic [arc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // red, green, blue, alpha, color_index (low to high), zero padded
    output logic [arc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // skipped
    output logic                           m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [arc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]         i_cfg_data
);
    import arc_pkg::*;

    localparam int IN_DATA_W = ((SAMPLE_BITS + ENTRY_W + COLOR_W + 7) / 8) * 8;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    arc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd),
        .i_status  (w_status)
    );

    arc_datapath #(
        .MAX_PALETTE (MAX_PALETTE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_DATA_W   (IN_DATA_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

endmodule
